/* rtl/sfd_pkg.sv */
package sfd_pkg;

  localparam int MaxDiffs = 7;

  // word codes from word 0 of a frame
  localparam logic [1:0] CODE_SKIP  = 2'd0;
  localparam logic [1:0] CODE_BYTES = 2'd1;
  localparam logic [1:0] CODE_HALF  = 2'd2;
  localparam logic [1:0] CODE_WIDE  = 2'd3;

  // Steim2 sub-codes (bits 31:30 of the assembled word)
  localparam logic [1:0] SUB2_D30 = 2'd1;
  localparam logic [1:0] SUB2_D15 = 2'd2;
  localparam logic [1:0] SUB2_D10 = 2'd3;
  localparam logic [1:0] SUB3_D6  = 2'd0;
  localparam logic [1:0] SUB3_D5  = 2'd1;
  localparam logic [1:0] SUB3_D4  = 2'd2;

  localparam logic MODE_STEIM1     = 1'b0;
  localparam logic HALF_HIGH_FIRST = 1'b0;

  // configuration register indexes
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_MAP  = 2'd1;
  localparam logic [1:0] REG_HALF = 2'd2;

  localparam logic [7:0] MAP_RESET = 8'd27;

  typedef logic [MaxDiffs-1:0][31:0] diff_vec_t;

  typedef struct packed {
    diff_vec_t  diff;
    logic [2:0] count;
  } unpack_t;

  // one decoded data word waiting for the accumulator
  typedef struct packed {
    diff_vec_t   diff;
    logic [2:0]  count;
    logic        load_init;
    logic        start;
    logic [15:0] limit;
  } entry_t;

  function automatic logic [31:0] assemble(logic [31:0] raw, logic [7:0] map);
    logic [31:0] w;
    logic [1:0]  pos;
    w   = '0;
    pos = '0;
    // later file bytes win on a collision
    for (int b = 0; b < 4; b++) begin
      pos = map[2*b +: 2];
      w[8*pos +: 8] = raw[31-8*b -: 8];
    end
    return w;
  endfunction

endpackage

/* rtl/steim_frame_decoder_core.sv */
// Steim1 / Steim2 record decoder.
// Input channel (in_valid_i / in_ready_o): one 32-bit record word per
// transaction, start_of_record_i marking word 0 of frame 0 together with the
// record's sample_limit_i. Output channel (out_valid_o / out_ready_i): one
// reconstructed sample per transaction with its index in the record;
// last_of_word_o flags the final sample shown for a word.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 mode, 1 byte map, 2 halfword order); write only while idle.
// Throughput: the accumulator handles one difference per cycle while the output
// is not stalled, and steps through every difference of a data word (1 to 7),
// counting differences past the sample limit. Code words, initial and final
// value words and words without differences cost one input transaction only.
// With the accumulator free, a word is first registered as a decoded entry and
// its first sample is then registered in the output register.
// A word is taken while the previous one finishes.
// Reset: configuration returns to Steim1, big-endian, and no record is open.
// Receiver stall: the output register and the decoded word hold; in_ready_o
// drops once a decoded word is waiting behind the stalled sample.
module steim_frame_decoder_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        raw_word_i,
  input  logic               start_of_record_i,
  input  logic [15:0]        sample_limit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sample_o,
  output logic [15:0]        sample_index_o,
  output logic               last_of_word_o
);
  import sfd_pkg::*;

  logic        mode_q;
  logic [7:0]  map_q;
  logic        half_q;

  logic [3:0]  wif_q, wif_d;
  logic        first_q, first_d;
  logic [31:0] codes_q, codes_d;
  logic [31:0] init_q, init_d;
  logic        pend_start_q, pend_start_d;
  logic [15:0] pend_limit_q, pend_limit_d;

  logic        accept;
  logic [3:0]  wif_eff;
  logic        first_eff;
  logic        is_codes;
  logic        is_init;
  logic        is_final;
  logic [31:0] code_sh;
  logic [1:0]  code;
  logic [31:0] asm_word;
  unpack_t     unp;
  entry_t      entry;
  logic        new_valid;
  logic        start_eff;
  logic [15:0] limit_eff;

  assign accept    = in_valid_i && in_ready_o;
  assign wif_eff   = start_of_record_i ? 4'd0 : wif_q;
  assign first_eff = start_of_record_i || first_q;
  assign is_codes  = (wif_eff == 4'd0);
  assign is_init   = first_eff && (wif_eff == 4'd1);
  assign is_final  = first_eff && (wif_eff == 4'd2);
  assign asm_word  = assemble(raw_word_i, map_q);

  // code for word j sits at bits 31-2j..30-2j
  assign code_sh = codes_q >> (5'd30 - {wif_eff, 1'b0});
  assign code    = code_sh[1:0];

  sfd_unpack u_unpack (
    .raw_word_i (raw_word_i),
    .code_i     (code),
    .mode_i     (mode_q),
    .map_i      (map_q),
    .half_i     (half_q),
    .unp_o      (unp)
  );

  assign start_eff = start_of_record_i || pend_start_q;
  assign limit_eff = start_of_record_i ? sample_limit_i : pend_limit_q;

  always_comb begin
    entry           = '0;
    entry.diff      = unp.diff;
    entry.count     = (is_codes || is_init || is_final) ? 3'd0 : unp.count;
    entry.load_init = first_eff && (wif_eff == 4'd3);
    entry.start     = start_eff;
    entry.limit     = limit_eff;
    if (entry.load_init) begin
      entry.diff[0] = init_q;
    end
  end

  assign new_valid = accept && (entry.count != 3'd0);

  always_comb begin
    wif_d        = wif_q;
    first_d      = first_q;
    codes_d      = codes_q;
    init_d       = init_q;
    pend_start_d = pend_start_q;
    pend_limit_d = pend_limit_q;
    if (accept) begin
      if (start_of_record_i) begin
        init_d = '0;
      end
      if (is_codes) begin
        codes_d = asm_word;
      end
      if (is_init) begin
        init_d = asm_word;
      end
      if (wif_eff == 4'd15) begin
        wif_d   = 4'd0;
        first_d = 1'b0;
      end else begin
        wif_d   = wif_eff + 4'd1;
        first_d = first_eff;
      end
      // a record start rides on the next word that carries differences
      if (entry.count != 3'd0) begin
        pend_start_d = 1'b0;
      end else begin
        pend_start_d = start_eff;
        pend_limit_d = limit_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_STEIM1;
      map_q        <= MAP_RESET;
      half_q       <= HALF_HIGH_FIRST;
      wif_q        <= '0;
      first_q      <= 1'b1;
      codes_q      <= '0;
      init_q       <= '0;
      pend_start_q <= 1'b0;
      pend_limit_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE: mode_q <= cfg_wdata_i[0];
          REG_MAP:  map_q  <= cfg_wdata_i;
          REG_HALF: half_q <= cfg_wdata_i[0];
          default:  ;
        endcase
      end
      wif_q        <= wif_d;
      first_q      <= first_d;
      codes_q      <= codes_d;
      init_q       <= init_d;
      pend_start_q <= pend_start_d;
      pend_limit_q <= pend_limit_d;
    end
  end

  sfd_emit #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .new_valid_i    (new_valid),
    .new_entry_i    (entry),
    .load_ready_o   (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_o       (sample_o),
    .sample_index_o (sample_index_o),
    .last_of_word_o (last_of_word_o)
  );

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !start_of_record_i && (wif_q == 4'd15) |=> (wif_q == 4'd0) && !first_q)
    else $error("frame word counter did not wrap");

  a_record_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && start_of_record_i |=> first_q && (wif_q == 4'd1))
    else $error("record start did not restart frame state");

  a_start_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && start_of_record_i |=> pend_start_q)
    else $error("record start lost before first data word");

endmodule

/* rtl/sfd_unpack.sv */
module sfd_unpack (
  input  logic [31:0]      raw_word_i,
  input  logic [1:0]       code_i,
  input  logic             mode_i,
  input  logic [7:0]       map_i,
  input  logic             half_i,
  output sfd_pkg::unpack_t unp_o
);
  import sfd_pkg::*;

  unpack_t     u;
  logic [31:0] w;
  logic [1:0]  s;
  logic [7:0]  a;
  logic [7:0]  c;
  logic [15:0] h;

  always_comb begin
    u = '0;
    a = '0;
    c = '0;
    h = '0;
    w = assemble(raw_word_i, map_i);
    s = w[31:30];
    case (code_i)
      CODE_BYTES: begin
        for (int k = 0; k < 4; k++) begin
          u.diff[k] = 32'($signed(raw_word_i[31-8*k -: 8]));
        end
        u.count = 3'd4;
      end
      CODE_HALF: begin
        if (mode_i == MODE_STEIM1) begin
          for (int k = 0; k < 2; k++) begin
            a = raw_word_i[31-16*k -: 8];
            c = raw_word_i[23-16*k -: 8];
            h = (half_i == HALF_HIGH_FIRST) ? {a, c} : {c, a};
            u.diff[k] = 32'($signed(h));
          end
          u.count = 3'd2;
        end else begin
          case (s)
            SUB2_D30: begin
              u.diff[0] = 32'($signed(w[29:0]));
              u.count   = 3'd1;
            end
            SUB2_D15: begin
              for (int k = 0; k < 2; k++) begin
                u.diff[k] = 32'($signed(w[29-15*k -: 15]));
              end
              u.count = 3'd2;
            end
            SUB2_D10: begin
              for (int k = 0; k < 3; k++) begin
                u.diff[k] = 32'($signed(w[29-10*k -: 10]));
              end
              u.count = 3'd3;
            end
            default: u.count = 3'd0;
          endcase
        end
      end
      CODE_WIDE: begin
        if (mode_i == MODE_STEIM1) begin
          u.diff[0] = w;
          u.count   = 3'd1;
        end else begin
          case (s)
            SUB3_D6: begin
              for (int k = 0; k < 5; k++) begin
                u.diff[k] = 32'($signed(w[29-6*k -: 6]));
              end
              u.count = 3'd5;
            end
            SUB3_D5: begin
              for (int k = 0; k < 6; k++) begin
                u.diff[k] = 32'($signed(w[29-5*k -: 5]));
              end
              u.count = 3'd6;
            end
            SUB3_D4: begin
              for (int k = 0; k < 7; k++) begin
                u.diff[k] = 32'($signed(w[27-4*k -: 4]));
              end
              u.count = 3'd7;
            end
            default: u.count = 3'd0;
          endcase
        end
      end
      default: u.count = 3'd0;
    endcase
  end

  assign unp_o = u;

endmodule

/* rtl/sfd_emit.sv */
module sfd_emit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               new_valid_i,
  input  sfd_pkg::entry_t    new_entry_i,
  output logic               load_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sample_o,
  output logic [15:0]        sample_index_o,
  output logic               last_of_word_o
);
  import sfd_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  entry_t                 entry_q;
  logic                   entry_valid_q, entry_valid_d;
  logic [2:0]             idx_q, idx_d;
  logic [31:0]            running_q, running_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] limit_q, limit_d;
  logic                   out_valid_q, out_valid_d;
  logic [31:0]            sample_q;
  logic [15:0]            index_q;
  logic                   last_q;

  logic                   first_diff;
  logic                   last_diff;
  logic                   step;
  logic                   emit;
  logic [31:0]            cur_run;
  logic [31:0]            diff_k;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] cur_lim;

  assign first_diff = (idx_q == 3'd0);
  assign last_diff  = (idx_q == (entry_q.count - 3'd1));
  assign step       = entry_valid_q && (!out_valid_q || out_ready_i);
  assign diff_k     = entry_q.diff[idx_q];

  // a new record clears the accumulator as its first difference goes through
  assign cur_run = (first_diff && entry_q.start) ? '0 : running_q;
  assign cur_cnt = (first_diff && entry_q.start) ? '0 : count_q;
  assign cur_lim = (first_diff && entry_q.start) ? COUNT_WIDTH'(entry_q.limit) : limit_q;
  assign emit    = (cur_cnt < cur_lim);

  assign load_ready_o = !entry_valid_q || (step && last_diff);

  always_comb begin
    running_d     = running_q;
    count_d       = count_q;
    limit_d       = limit_q;
    idx_d         = idx_q;
    entry_valid_d = entry_valid_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    if (step) begin
      running_d   = (first_diff && entry_q.load_init) ? diff_k : cur_run + diff_k;
      count_d     = (cur_cnt == CountMax) ? cur_cnt : cur_cnt + 1'b1;
      limit_d     = cur_lim;
      idx_d       = idx_q + 3'd1;
      out_valid_d = emit;
      if (last_diff) begin
        entry_valid_d = 1'b0;
      end
    end
    if (new_valid_i && load_ready_o) begin
      entry_valid_d = 1'b1;
      idx_d         = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
      idx_q         <= '0;
      running_q     <= '0;
      count_q       <= '0;
      limit_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      entry_valid_q <= entry_valid_d;
      idx_q         <= idx_d;
      running_q     <= running_d;
      count_q       <= count_d;
      limit_q       <= limit_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_valid_i && load_ready_o) begin
      entry_q <= new_entry_i;
    end
    if (step && emit) begin
      sample_q <= running_d;
      index_q  <= 16'(cur_cnt);
      // past the limit nothing more of this word is shown
      last_q   <= last_diff || (COUNT_WIDTH'(cur_cnt + 1'b1) == cur_lim);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign sample_index_o = index_q;
  assign last_of_word_o = last_q;

endmodule

/* sim/steim_frame_decoder_core_tb.sv */
`timescale 1ns / 100ps

module steim_frame_decoder_core_tb;
  import sfd_pkg::*;

  localparam int HoldCycles = 400;
  localparam int IdleGap = 16;
  localparam int PhaseWords = 28;
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam logic ModeSteim2 = ~MODE_STEIM1;
  localparam logic HalfLowFirst = ~HALF_HIGH_FIRST;

  // Steim1 record: bytes, halves, wide, skip, halves, bytes
  localparam logic [31:0] S1Codes = {CODE_SKIP, CODE_SKIP, CODE_SKIP, CODE_BYTES,
                                     CODE_HALF, CODE_WIDE, CODE_SKIP, CODE_HALF,
                                     CODE_BYTES, {7{CODE_SKIP}}};
  // Steim2 record: every sub-code of both wide codes, then bytes
  localparam logic [31:0] S2Codes = {CODE_SKIP, CODE_SKIP, CODE_SKIP, CODE_HALF,
                                     CODE_HALF, CODE_HALF, CODE_HALF, CODE_WIDE,
                                     CODE_WIDE, CODE_WIDE, CODE_WIDE, CODE_BYTES,
                                     {4{CODE_SKIP}}};

  typedef struct packed {
    logic signed [31:0] value;
    logic [15:0]        index;
    logic               last;
  } sample_t;

  class sample_scoreboard;
    logic        mode = MODE_STEIM1;
    logic [7:0]  byte_map = MAP_RESET;
    logic        half_order = HALF_HIGH_FIRST;
    logic [3:0]  word_pos = '0;
    logic        first_frame = 1'b1;
    logic [31:0] codes = '0;
    logic [31:0] init_val = '0;
    logic [31:0] run_val = '0;
    logic [15:0] count = '0;
    logic [15:0] limit = '0;
    logic [31:0] diffs [7];
    sample_t     expected_samples [$];
    int          errors = 0;

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_MODE: mode = val[0];
        REG_MAP:  byte_map = val;
        REG_HALF: half_order = val[0];
        default:  ;
      endcase
    endfunction

    function logic [31:0] gather(logic [31:0] raw);
      logic [31:0] w;
      logic [1:0]  p;
      w = '0;
      for (int b = 0; b < 4; b++) begin
        p = byte_map[2*b +: 2];
        w[8*p +: 8] = raw[31-8*b -: 8];
      end
      return w;
    endfunction

    function logic [31:0] sext(logic [31:0] v, int n);
      logic [31:0] m;
      m = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
      v = v & m;
      if (n < 32 && v[n-1]) v = v | ~m;
      return v;
    endfunction

    function int split(logic [31:0] w, int top, int width, int n);
      int lo;
      for (int k = 0; k < n; k++) begin
        lo = top + 1 - width * (k + 1);
        diffs[k] = sext(w >> lo, width);
      end
      return n;
    endfunction

    function int unpack(logic [31:0] raw, logic [1:0] code);
      logic [31:0] w;
      logic [1:0]  sub;
      logic [7:0]  a;
      logic [7:0]  c;
      logic [15:0] h;
      w = gather(raw);
      sub = w[31:30];
      // byte differences ignore the byte map
      if (code == CODE_BYTES) begin
        for (int k = 0; k < 4; k++) diffs[k] = sext({24'd0, raw[31-8*k -: 8]}, 8);
        return 4;
      end
      if (mode == MODE_STEIM1) begin
        if (code == CODE_HALF) begin
          for (int k = 0; k < 2; k++) begin
            a = raw[31-16*k -: 8];
            c = raw[23-16*k -: 8];
            h = (half_order == HALF_HIGH_FIRST) ? {a, c} : {c, a};
            diffs[k] = sext({16'd0, h}, 16);
          end
          return 2;
        end
        if (code == CODE_WIDE) begin
          diffs[0] = w;
          return 1;
        end
        return 0;
      end
      if (code == CODE_HALF) begin
        case (sub)
          SUB2_D30: return split(w, 29, 30, 1);
          SUB2_D15: return split(w, 29, 15, 2);
          SUB2_D10: return split(w, 29, 10, 3);
          default:  return 0;
        endcase
      end
      if (code == CODE_WIDE) begin
        case (sub)
          SUB3_D6: return split(w, 29, 6, 5);
          SUB3_D5: return split(w, 29, 5, 6);
          SUB3_D4: return split(w, 27, 4, 7);
          default: return 0;
        endcase
      end
      return 0;
    endfunction

    function void note_word(logic [31:0] raw, logic sor, logic [15:0] lim);
      sample_t    fresh [7];
      int         nd;
      int         nout;
      int         j;
      logic [1:0] code;
      if (sor) begin
        word_pos = '0;
        first_frame = 1'b1;
        init_val = '0;
        run_val = '0;
        count = '0;
        limit = lim;
      end
      nd = 0;
      nout = 0;
      j = word_pos;
      if (j == 0) begin
        codes = gather(raw);
      end else if (first_frame && j == 1) begin
        init_val = gather(raw);
      end else if (!(first_frame && j == 2)) begin
        code = codes[2*(15-j) +: 2];
        nd = unpack(raw, code);
      end
      for (int k = 0; k < nd; k++) begin
        // first difference of frame 0 word 3 only loads the initial value
        if (first_frame && j == 3 && k == 0) run_val = init_val;
        else run_val = run_val + diffs[k];
        if (count < limit) begin
          fresh[nout] = '{value: run_val, index: count, last: 1'b0};
          nout++;
        end
        if (count != CountMax) count++;
      end
      for (int k = 0; k < nout; k++) begin
        if (k == nout - 1) fresh[k].last = 1'b1;
        expected_samples.push_back(fresh[k]);
      end
      if (j == 15) begin
        word_pos = '0;
        first_frame = 1'b0;
      end else begin
        word_pos = word_pos + 4'd1;
      end
    endfunction

    function void check_sample(logic signed [31:0] value, logic [15:0] index, logic last);
      sample_t want;
      if (expected_samples.size() == 0) begin
        $error("unexpected sample %0d at index %0d", value, index);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      if (value !== want.value) begin
        $error("sample: expected %0d, actual %0d", want.value, value);
        errors++;
      end
      if (index !== want.index) begin
        $error("sample_index: expected %0d, actual %0d", want.index, index);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_word: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [1:0]         cfg_idx;
  logic [7:0]         cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [31:0]        raw_word;
  logic               start_of_record;
  logic [15:0]        sample_limit;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] sample;
  logic [15:0]        sample_index;
  logic               last_of_word;

  int               send_idle_pct;
  int               recv_stall_pct;
  logic             hold_on;
  int               hold_cnt;
  int               words_sent;
  sample_scoreboard sb;

  logic [31:0] steim1_words [9] = '{S1Codes, 32'h7FFF_FFFF, 32'h1234_5678, 32'h807F_00FF,
                                    32'h8000_7FFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                    32'h7FFF_0001, 32'h0180_7FFF};
  logic [31:0] steim2_words [12] = '{S2Codes, 32'h8000_0000, 32'h0BAD_F00D, 32'h3FFF_FFFF,
                                     32'h5FFF_FFFF, 32'hA000_4000, 32'hFFFF_FFFF,
                                     32'h2000_0000, 32'h7FFF_FFFF, 32'h8765_4321,
                                     32'hC000_0000, 32'h7F80_017F};

  steim_frame_decoder_core #(
    .COUNT_WIDTH(16)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .raw_word_i       (raw_word),
    .start_of_record_i(start_of_record),
    .sample_limit_i   (sample_limit),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .sample_o         (sample),
    .sample_index_o   (sample_index),
    .last_of_word_o   (last_of_word)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // output side: check each transaction, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      sb.check_sample(sample, sample_index, last_of_word);
    end
    if (hold_on && hold_cnt < HoldCycles) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!hold_on) hold_cnt <= 0;
    end
  end

  task automatic send_word(logic [31:0] raw, logic sor, logic [15:0] lim);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    raw_word <= raw;
    start_of_record <= sor;
    sample_limit <= lim;
    do @(posedge clk_i); while (!in_ready);
    sb.note_word(raw, sor, lim);
  endtask

  // drain results, then allow for words still in the accumulator
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (IdleGap) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic m, logic [7:0] map, logic h);
    logic [6:0] junk;
    junk = 7'($urandom);
    write_reg(REG_MODE, {junk, m});
    junk = 7'($urandom);
    write_reg(REG_HALF, {junk, h});
    write_reg(REG_MAP, map);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 60));
    endcase
  endfunction

  task automatic send_record(int nwords);
    logic [15:0] lim;
    logic [31:0] raw;
    lim = pick_limit();
    for (int i = 0; i < nwords; i++) begin
      raw = $urandom;
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: raw = 32'h0000_0000;
          1: raw = 32'hFFFF_FFFF;
          2: raw = 32'h8000_0000;
          default: raw = 32'h7FFF_FFFF;
        endcase
      end
      send_word(raw, (i == 0), (i == 0) ? lim : 16'($urandom));
      words_sent++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_MODE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    raw_word = '0;
    start_of_record = 1'b0;
    sample_limit = '0;
    out_ready = 1'b0;
    hold_on = 1'b0;
    hold_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    words_sent = 0;
    sb = new;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // words before any record start emit nothing
    send_word($urandom, 1'b0, 16'($urandom));
    send_word(32'hFFFF_FFFF, 1'b0, 16'hFFFF);
    for (int i = 0; i < 9; i++) send_word(steim1_words[i], (i == 0), (i == 0) ? 16'hFFFF : 16'h0);
    wait_idle();
    configure(ModeSteim2, MAP_RESET, HALF_HIGH_FIRST);
    // limit 10 cuts the record short; word 3 carries no differences
    for (int i = 0; i < 12; i++) send_word(steim2_words[i], (i == 0), (i == 0) ? 16'd10 : 16'h0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          configure(MODE_STEIM1, 8'hE4, HalfLowFirst);
          hold_on <= 1'b1;
        end
        1: begin
          send_idle_pct = 85;
          recv_stall_pct = 0;
          configure(ModeSteim2, MAP_RESET, HALF_HIGH_FIRST);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 85;
          configure(MODE_STEIM1, 8'h00, HALF_HIGH_FIRST);
        end
        default: begin
          send_idle_pct = 29;
          recv_stall_pct = 29;
          configure(ModeSteim2, 8'hFF, HalfLowFirst);
        end
      endcase
      words_sent = 0;
      while (words_sent < PhaseWords) begin
        if ($urandom_range(4) == 0) send_record($urandom_range(1, 3));
        else send_record($urandom_range(8, 34));
      end
      wait_idle();
      hold_on <= 1'b0;
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("steim_frame_decoder_core_tb OK");
    end else begin
      $display("steim_frame_decoder_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("steim_frame_decoder_core_tb NOT OK");
    $finish;
  end

endmodule
